// ===== rtl/core/sdtq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_pkg
// Shared types and constants for the sorted deadline timer queue.
// ----------------------------------------------------------------------------
package sdtq_pkg;

  localparam int MAX_TIMERS = 16;
  localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
  localparam int ID_W       = 4;
  localparam int TICK_W     = 32;
  localparam int ACT_W      = 2;
  localparam int QCOUNT_W   = 5;

  localparam logic [ACT_W-1:0] ACT_INSTALL = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   client_id;
    logic [TICK_W-1:0] interval;
    logic [TICK_W-1:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic                fired;
    logic [ID_W-1:0]     fired_id;
    logic [QCOUNT_W-1:0] queue_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, clear pointer and result
    logic clr_ptr;
    logic inc_ptr;
    logic do_remove;  // close the gap at the pointer
    logic do_insert;  // open a gap at the pointer and write the new timer
    logic set_fired;  // record the head owner as fired
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ptr_end;    // pointer reached the fill count
    logic own_hit;    // slot at pointer belongs to the item's id
    logic dl_ge;      // slot deadline at pointer >= new deadline
    logic full;
    logic head_due;
  } dp_status_t;

endpackage : sdtq_pkg
`default_nettype wire

// ===== rtl/core/sdtq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_dp
// Datapath: sorted slot shift array, scan pointer, item and result registers.
// ----------------------------------------------------------------------------
module sdtq_dp (
  input  wire                    clk,
  input  wire                    rst_n,
  input  sdtq_pkg::in_item_t     in_item,
  input  sdtq_pkg::ctrl_cmd_t    cmd,
  output sdtq_pkg::dp_status_t   st,
  output sdtq_pkg::out_item_t    out_item
);
  import sdtq_pkg::*;

  logic [ID_W-1:0]   own_r [MAX_TIMERS];
  logic [TICK_W-1:0] dl_r  [MAX_TIMERS];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [ID_W-1:0]   id_r;
  logic [TICK_W-1:0] dl_new_r;
  logic [TICK_W-1:0] now_r;
  logic              fired_r;
  logic [ID_W-1:0]   fired_id_r;
  logic [IDX_W-1:0]  idx;

  assign idx = ptr_r[IDX_W-1:0];

  // pointer slot is only looked at while ptr_r < count_r
  always_comb begin
    st.ptr_end  = (ptr_r == count_r);
    st.own_hit  = (own_r[idx] == id_r);
    st.dl_ge    = (dl_r[idx] >= dl_new_r);
    st.full     = (count_r == CNT_W'(MAX_TIMERS));
    st.head_due = (count_r != '0) && (now_r >= dl_r[0]);
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load || cmd.clr_ptr) begin
      ptr_nxt = '0;
    end else if (cmd.inc_ptr) begin
      ptr_nxt = ptr_r + CNT_W'(1);
    end
    count_nxt = count_r;
    if (cmd.do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      count_r <= '0;
    end else begin
      ptr_r   <= ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r       <= in_item.client_id;
      dl_new_r   <= in_item.now_ticks + in_item.interval;
      now_r      <= in_item.now_ticks;
      fired_r    <= 1'b0;
      fired_id_r <= '0;
    end else if (cmd.set_fired) begin
      fired_r    <= 1'b1;
      fired_id_r <= own_r[0];
    end
  end

  // each slot only takes from its neighbors or the new timer
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (cmd.do_remove) begin
        if ((i < MAX_TIMERS - 1) && (CNT_W'(i) >= ptr_r)) begin
          own_r[i] <= own_r[(i + 1) % MAX_TIMERS];
          dl_r[i]  <= dl_r[(i + 1) % MAX_TIMERS];
        end
      end else if (cmd.do_insert) begin
        if (CNT_W'(i) == ptr_r) begin
          own_r[i] <= id_r;
          dl_r[i]  <= dl_new_r;
        end else if ((i > 0) && (CNT_W'(i) > ptr_r)) begin
          own_r[i] <= own_r[(i + MAX_TIMERS - 1) % MAX_TIMERS];
          dl_r[i]  <= dl_r[(i + MAX_TIMERS - 1) % MAX_TIMERS];
        end
      end
    end
  end

  assign out_item.fired       = fired_r;
  assign out_item.fired_id    = fired_id_r;
  assign out_item.queue_count = QCOUNT_W'(count_r);

endmodule : sdtq_dp
`default_nettype wire

// ===== rtl/core/sdtq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sdtq_ctrl
// Controller: sequences remove scan, insert scan and head check per item.
// ----------------------------------------------------------------------------
module sdtq_ctrl (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire [sdtq_pkg::ACT_W-1:0]     action,
  input  sdtq_pkg::dp_status_t          st,
  output sdtq_pkg::ctrl_cmd_t           cmd,
  output logic                          busy,
  output logic                          out_valid
);
  import sdtq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_RM_SCAN  = 5'b00010,
    S_INS_SCAN = 5'b00100,
    S_TICK     = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   ins_r, ins_nxt;

  always_comb begin
    state_nxt = state_r;
    ins_nxt   = ins_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          ins_nxt  = (action == ACT_INSTALL);
          if (action == ACT_INSTALL || action == ACT_REMOVE) begin
            state_nxt = S_RM_SCAN;
          end else if (action == ACT_TICK) begin
            state_nxt = S_TICK;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_RM_SCAN: begin
        if (st.ptr_end || st.own_hit) begin
          cmd.do_remove = !st.ptr_end;
          cmd.clr_ptr   = 1'b1;
          state_nxt     = ins_r ? S_INS_SCAN : S_DONE;
        end else begin
          cmd.inc_ptr = 1'b1;
        end
      end
      S_INS_SCAN: begin
        priority if (st.full) begin
          state_nxt = S_DONE;
        end else if (st.ptr_end || st.dl_ge) begin
          cmd.do_insert = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          cmd.inc_ptr = 1'b1;
        end
      end
      S_TICK: begin
        // pointer is zero here, so remove pops the head
        if (st.head_due) begin
          cmd.do_remove = 1'b1;
          cmd.set_fired = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ins_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ins_r   <= ins_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule : sdtq_ctrl
`default_nettype wire

// ===== rtl/core/sorted_deadline_timer_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue
// One-shot timers kept in ascending deadline order, one per client id.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Busy then stays high
// through the result strobe cycle and drops in the cycle after it. The result
// appears for one cycle with out_valid high and must be captured then: there
// is no way to hold it off. A tick checks the head once, and an unused action
// code goes straight to the result strobe. A remove walks the slots one per
// cycle looking for the id. An install runs that walk and then a second
// one-slot-per-cycle walk to find the insert point. The slot store is a shift
// array, so a gap is opened or closed in the same cycle that finds the slot.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sorted_deadline_timer_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  sdtq_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output sdtq_pkg::out_item_t  out_item
);
  import sdtq_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  sdtq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_item.action),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  sdtq_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .st       (st),
    .out_item (out_item)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy held after result strobe");

  a_fired_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.fired) |-> (out_item.fired_id == '0))
    else $error("fired_id nonzero without a fired timer");

  a_no_dual_shift: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.do_remove && cmd.do_insert))
    else $error("remove and insert commanded together");

endmodule : sorted_deadline_timer_queue
`default_nettype wire
